@@ sv/datetime_text_validator_defines.svh @@
// Assertion macros for the datetime text validator.
`ifndef DATETIME_TEXT_VALIDATOR_DEFINES_SVH
`define DATETIME_TEXT_VALIDATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DTV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTV_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTV_ASSERT(label, clk, rst, prop, msg)
`define DTV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ sv/dtv_pkg.sv @@
// Types, constants and helper functions for the datetime text validator.
package dtv_pkg;

  typedef enum logic [20:0] {
    PH_LEAD      = 21'h000001,
    PH_Y1        = 21'h000002,
    PH_Y2        = 21'h000004,
    PH_Y3        = 21'h000008,
    PH_DASH1     = 21'h000010,
    PH_M0        = 21'h000020,
    PH_M1        = 21'h000040,
    PH_DASH2     = 21'h000080,
    PH_D0        = 21'h000100,
    PH_D1        = 21'h000200,
    PH_DATE_DONE = 21'h000400,
    PH_H0        = 21'h000800,
    PH_H1        = 21'h001000,
    PH_COLON     = 21'h002000,
    PH_MI0       = 21'h004000,
    PH_MI1       = 21'h008000,
    PH_TIME_DONE = 21'h010000,
    PH_S0        = 21'h020000,
    PH_S1        = 21'h040000,
    PH_TAIL      = 21'h080000,
    PH_ENDED     = 21'h100000
  } phase_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] char_code;
    logic       is_last;
  } item_t;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_T_UP  = 8'h54;
  localparam logic [7:0] CHAR_T_LO  = 8'h74;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [6:0] MAX_MONTH  = 7'd12;
  localparam logic [6:0] MAX_HOUR   = 7'd23;
  localparam logic [6:0] MAX_MINSEC = 7'd59;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [4:0] DAYS_LEAP  = 5'd29;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic accepting(input phase_t ph);
    return (ph == PH_DATE_DONE) || (ph == PH_TIME_DONE) || (ph == PH_TAIL);
  endfunction

  function automatic logic [6:0] times10_add(input logic [6:0] a, input logic [3:0] d);
    return 7'((a << 3) + (a << 1) + {3'b000, d});
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:    r = 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

@@ sv/dtv_intf.sv @@
// Handshake interfaces for the text byte and result channels.
interface dtv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  modport source(output valid, output char_code, output is_last, input ready);
  modport sink(input valid, input char_code, input is_last, output ready);
endinterface

interface dtv_res_if;
  logic valid;
  logic ready;
  logic valid_res;
  modport source(output valid, output valid_res, input ready);
  modport sink(input valid, input valid_res, output ready);
endinterface

@@ sv/datetime_text_validator.sv @@
// The last text byte is held in the input register, then its verdict loads the result register.
// Throughput: one text byte per cycle, except while a last byte waits on a pending result
// that is not taken; the per-byte grammar update sets the rate.
// A pending result does not block bytes that are not marked last.
// Reset: synchronous rst empties both registers and returns the parser to leading whitespace.
// No memories, no clearing pass after reset.
module datetime_text_validator (
  input logic        clk,
  input logic        rst,
  dtv_text_if.sink   text,
  dtv_res_if.source  result
);

  dtv_pkg::item_t item;
  logic           take;

  dtv_in_reg u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .take (take),
    .item (item)
  );

  dtv_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .take   (take),
    .result (result)
  );

endmodule

@@ sv/dtv_in_reg.sv @@
// Input register stage for text bytes.
`include "datetime_text_validator_defines.svh"
module dtv_in_reg (
  input  logic           clk,
  input  logic           rst,
  dtv_text_if.sink       text,
  input  logic           take,
  output dtv_pkg::item_t item
);

  logic       vld;
  logic [7:0] char_code;
  logic       is_last;
  logic       load;

  assign text.ready = !vld || take;
  assign load       = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_code <= text.char_code;
      is_last   <= text.is_last;
    end
  end

  assign item = '{vld: vld, char_code: char_code, is_last: is_last};

  `DTV_ASSERT(a_take_needs_item, clk, rst, take |-> vld, "consume without held byte")
  `DTV_ASSERT(a_stall_holds_byte, clk, rst, vld && !take |=> vld && $stable(char_code), "held byte lost")

endmodule

@@ sv/dtv_parse.sv @@
// Grammar and calendar check per byte, with result register.
`include "datetime_text_validator_defines.svh"
module dtv_parse (
  input  logic           clk,
  input  logic           rst,
  input  dtv_pkg::item_t item,
  output logic           take,
  dtv_res_if.source      result
);

  dtv_pkg::phase_t phase, phase_next;
  logic            rejected, rejected_next;
  logic [6:0]      year_hi, year_hi_next;
  logic [6:0]      year_lo, year_lo_next;
  logic [3:0]      month, month_next;
  logic [3:0]      day_d0, day_d0_next;
  logic [3:0]      first_time_digit, first_time_digit_next;
  logic            out_valid;
  logic            out_res;
  logic            res_next;
  logic            ok;
  logic [7:0]      c;
  logic            dg;
  logic            ws;
  logic [3:0]      d;
  logic [6:0]      val2;
  logic [6:0]      month_val;
  logic [6:0]      day_val;
  logic            leap;
  logic [4:0]      max_day;

  assign c  = item.char_code;
  assign dg = dtv_pkg::is_digit(c);
  assign ws = dtv_pkg::is_ws(c);
  assign d  = c[3:0];

  assign val2      = dtv_pkg::times10_add({3'b000, first_time_digit}, d);
  assign month_val = dtv_pkg::times10_add({3'b000, month}, d);
  assign day_val   = dtv_pkg::times10_add({3'b000, day_d0}, d);
  assign leap      = (year_lo == 7'd0) ? (year_hi[1:0] == 2'b00) : (year_lo[1:0] == 2'b00);
  assign max_day   = (month == dtv_pkg::MONTH_FEB && leap) ? dtv_pkg::DAYS_LEAP
                                                           : dtv_pkg::month_days(month);

  assign take = item.vld && (!item.is_last || !out_valid || result.ready);

  always_comb begin
    phase_next            = phase;
    rejected_next         = rejected;
    year_hi_next          = year_hi;
    year_lo_next          = year_lo;
    month_next            = month;
    day_d0_next           = day_d0;
    first_time_digit_next = first_time_digit;
    ok                    = 1'b1;
    if (!rejected && phase != dtv_pkg::PH_ENDED) begin
      if (c == dtv_pkg::CHAR_NUL) begin
        rejected_next = !dtv_pkg::accepting(phase);
        phase_next    = dtv_pkg::PH_ENDED;
      end else begin
        case (phase)
          dtv_pkg::PH_LEAD: begin
            if (!ws) begin
              ok           = dg;
              year_hi_next = {3'b000, d};
              phase_next   = dtv_pkg::PH_Y1;
            end
          end
          dtv_pkg::PH_Y1: begin
            ok           = dg;
            year_hi_next = dtv_pkg::times10_add(year_hi, d);
            phase_next   = dtv_pkg::PH_Y2;
          end
          dtv_pkg::PH_Y2: begin
            ok           = dg;
            year_lo_next = {3'b000, d};
            phase_next   = dtv_pkg::PH_Y3;
          end
          dtv_pkg::PH_Y3: begin
            ok           = dg;
            year_lo_next = dtv_pkg::times10_add(year_lo, d);
            phase_next   = dtv_pkg::PH_DASH1;
          end
          dtv_pkg::PH_DASH1: begin
            ok         = (c == dtv_pkg::CHAR_DASH);
            phase_next = dtv_pkg::PH_M0;
          end
          dtv_pkg::PH_M0: begin
            ok         = dg;
            month_next = d;
            phase_next = dtv_pkg::PH_M1;
          end
          dtv_pkg::PH_M1: begin
            ok         = dg && (month_val != 7'd0) && (month_val <= dtv_pkg::MAX_MONTH);
            month_next = month_val[3:0];
            phase_next = dtv_pkg::PH_DASH2;
          end
          dtv_pkg::PH_DASH2: begin
            ok         = (c == dtv_pkg::CHAR_DASH);
            phase_next = dtv_pkg::PH_D0;
          end
          dtv_pkg::PH_D0: begin
            ok          = dg;
            day_d0_next = d;
            phase_next  = dtv_pkg::PH_D1;
          end
          dtv_pkg::PH_D1: begin
            ok         = dg && (day_val != 7'd0) && (day_val <= {2'b00, max_day});
            phase_next = dtv_pkg::PH_DATE_DONE;
          end
          dtv_pkg::PH_DATE_DONE: begin
            if (c == dtv_pkg::CHAR_T_UP || c == dtv_pkg::CHAR_T_LO) begin
              phase_next = dtv_pkg::PH_H0;
            end else if (!ws) begin
              ok                    = dg;
              first_time_digit_next = d;
              phase_next            = dtv_pkg::PH_H1;
            end
          end
          dtv_pkg::PH_H0: begin
            ok                    = dg;
            first_time_digit_next = d;
            phase_next            = dtv_pkg::PH_H1;
          end
          dtv_pkg::PH_H1: begin
            ok         = dg && (val2 <= dtv_pkg::MAX_HOUR);
            phase_next = dtv_pkg::PH_COLON;
          end
          dtv_pkg::PH_COLON: begin
            ok         = (c == dtv_pkg::CHAR_COLON);
            phase_next = dtv_pkg::PH_MI0;
          end
          dtv_pkg::PH_MI0: begin
            ok                    = dg;
            first_time_digit_next = d;
            phase_next            = dtv_pkg::PH_MI1;
          end
          dtv_pkg::PH_MI1: begin
            ok         = dg && (val2 <= dtv_pkg::MAX_MINSEC);
            phase_next = dtv_pkg::PH_TIME_DONE;
          end
          dtv_pkg::PH_TIME_DONE: begin
            if (c == dtv_pkg::CHAR_COLON) begin
              phase_next = dtv_pkg::PH_S0;
            end else begin
              ok         = ws;
              phase_next = dtv_pkg::PH_TAIL;
            end
          end
          dtv_pkg::PH_S0: begin
            ok                    = dg;
            first_time_digit_next = d;
            phase_next            = dtv_pkg::PH_S1;
          end
          dtv_pkg::PH_S1: begin
            ok         = dg && (val2 <= dtv_pkg::MAX_MINSEC);
            phase_next = dtv_pkg::PH_TAIL;
          end
          dtv_pkg::PH_TAIL: begin
            ok = ws;
          end
          default: begin
            ok = 1'b1;
          end
        endcase
        if (!ok) begin
          rejected_next = 1'b1;
          phase_next    = phase;
        end
      end
    end
    res_next = !rejected_next &&
               (phase_next == dtv_pkg::PH_ENDED || dtv_pkg::accepting(phase_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dtv_pkg::PH_LEAD;
      rejected  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        if (item.is_last) begin
          phase    <= dtv_pkg::PH_LEAD;
          rejected <= 1'b0;
        end else begin
          phase    <= phase_next;
          rejected <= rejected_next;
        end
      end
      if (take && item.is_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      year_hi          <= year_hi_next;
      year_lo          <= year_lo_next;
      month            <= month_next;
      day_d0           <= day_d0_next;
      first_time_digit <= first_time_digit_next;
    end
    if (take && item.is_last) begin
      out_res <= res_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.valid_res = out_res;

  `DTV_ASSERT(a_no_result_overwrite, clk, rst, out_valid && !result.ready |-> !(take && item.is_last), "pending result overwritten")
  `DTV_ASSERT(a_result_from_last, clk, rst, $rose(out_valid) |-> $past(take && item.is_last), "result without last byte")
  `DTV_ASSERT(a_restart_after_last, clk, rst, take && item.is_last |=> phase == dtv_pkg::PH_LEAD && !rejected, "state not restarted after last byte")
  `DTV_ASSERT_NR(a_reset_clears_result, clk, $past(rst) |-> !out_valid, "result pending after reset")

endmodule

@@ bench/tb_datetime_text_validator.sv @@
// Self-checking testbench for the datetime text validator: directed texts, then random ones.
module tb_datetime_text_validator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int USE_MODEL      = -1;
  localparam int DIR_ROWS       = 26;
  localparam int PHASE_BYTES    = 100;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_VT        = 8'h0B;
  localparam logic [7:0] CHAR_FF        = 8'h0C;
  localparam logic [7:0] CHAR_HIGH_ZERO = 8'hB0;

  localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} stall_mode_t;

  logic clk = 1'b0;
  logic rst;

  dtv_text_if text_ch();
  dtv_res_if  res_ch();

  datetime_text_validator u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // '~' stands for a zero byte, '^' for a byte with bit 7 set.
  string dir_text [DIR_ROWS] = '{
    "2024-02-29",
    "2023-02-29",
    "0000-02-29",
    "1900-02-29",
    "2000-02-29",
    " \t\n\013\014\0159999-12-31T23:59:59 \015",
    "2024-01-01t00:00",
    "2024-13-01",
    "2024-00-10",
    "2024-04-31",
    "2024-04-00",
    "2024-06-15 24:00",
    "2024-06-15 12:60",
    "2024-06-1512:34:60",
    "2024-06-1512:34",
    "2024-06-15T",
    "2024-06-15 12:3",
    "2024-06-15~x9",
    "~",
    "x2024-06-15",
    "2024-06-15 ",
    "2024-06-15T12:34 x",
    "2^24-06-15",
    "2024-06-15 12:34:56~~",
    "0001-01-01 00:00:00",
    "1970-01-01\t07:30 "
  };

  int dir_answer [DIR_ROWS] = '{
    1, 0, 1, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, USE_MODEL, 0, 0, 1, 0, 0,
    USE_MODEL, 0, 0, 1, USE_MODEL, USE_MODEL
  };

  stall_mode_t mode;
  logic [7:0]  text_bytes[$];
  bit          verdict_q[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          texts_sent = 0;
  int          verdicts_checked = 0;
  int          verdicts_true = 0;

  // Parser state of the predictor.
  dtv_pkg::phase_t ph;
  logic [13:0]     yr;
  logic [6:0]      mo;
  logic [6:0]      dy;
  logic [3:0]      tdig;
  bit              bad;

  function automatic bit ws_char(logic [7:0] c);
    return c == dtv_pkg::CHAR_SPACE || (c >= dtv_pkg::CHAR_TAB && c <= dtv_pkg::CHAR_CR);
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= dtv_pkg::CHAR_ZERO && c <= dtv_pkg::CHAR_NINE;
  endfunction

  function automatic bit phase_accepts(dtv_pkg::phase_t p);
    return p == dtv_pkg::PH_DATE_DONE || p == dtv_pkg::PH_TIME_DONE || p == dtv_pkg::PH_TAIL;
  endfunction

  function automatic int month_length(int m, int y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == 2 && leap) return 29;
    return DAYS_IN_MONTH[(m - 1) % 12];
  endfunction

  task automatic clear_parser();
    ph   = dtv_pkg::PH_LEAD;
    yr   = '0;
    mo   = '0;
    dy   = '0;
    tdig = '0;
    bad  = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] c, output bit ok);
    bit dg;
    logic [3:0] d;
    dg = digit_char(c);
    d  = dg ? 4'(c - dtv_pkg::CHAR_ZERO) : 4'd0;
    ok = 1'b1;
    case (ph)
      dtv_pkg::PH_LEAD: begin
        if (!ws_char(c)) begin
          if (!dg) ok = 1'b0;
          else begin
            yr = 14'(d);
            ph = dtv_pkg::PH_Y1;
          end
        end
      end
      dtv_pkg::PH_Y1, dtv_pkg::PH_Y2, dtv_pkg::PH_Y3: begin
        if (!dg) ok = 1'b0;
        else begin
          yr = 14'(int'(yr) * 10 + int'(d));
          ph = (ph == dtv_pkg::PH_Y1) ? dtv_pkg::PH_Y2 :
               (ph == dtv_pkg::PH_Y2) ? dtv_pkg::PH_Y3 : dtv_pkg::PH_DASH1;
        end
      end
      dtv_pkg::PH_DASH1, dtv_pkg::PH_DASH2: begin
        if (c != dtv_pkg::CHAR_DASH) ok = 1'b0;
        else ph = (ph == dtv_pkg::PH_DASH1) ? dtv_pkg::PH_M0 : dtv_pkg::PH_D0;
      end
      dtv_pkg::PH_M0: begin
        if (!dg) ok = 1'b0;
        else begin
          mo = 7'(d);
          ph = dtv_pkg::PH_M1;
        end
      end
      dtv_pkg::PH_M1: begin
        if (!dg) ok = 1'b0;
        else begin
          mo = 7'(int'(mo) * 10 + int'(d));
          if (mo < 1 || mo > 12) ok = 1'b0;
          else ph = dtv_pkg::PH_DASH2;
        end
      end
      dtv_pkg::PH_D0: begin
        if (!dg) ok = 1'b0;
        else begin
          dy = 7'(d);
          ph = dtv_pkg::PH_D1;
        end
      end
      dtv_pkg::PH_D1: begin
        if (!dg) ok = 1'b0;
        else begin
          dy = 7'(int'(dy) * 10 + int'(d));
          if (dy < 1 || int'(dy) > month_length(int'(mo), int'(yr))) ok = 1'b0;
          else ph = dtv_pkg::PH_DATE_DONE;
        end
      end
      dtv_pkg::PH_DATE_DONE: begin
        if (c == dtv_pkg::CHAR_T_UP || c == dtv_pkg::CHAR_T_LO) ph = dtv_pkg::PH_H0;
        else if (!ws_char(c)) begin
          if (!dg) ok = 1'b0;
          else begin
            tdig = d;
            ph   = dtv_pkg::PH_H1;
          end
        end
      end
      dtv_pkg::PH_H0, dtv_pkg::PH_MI0, dtv_pkg::PH_S0: begin
        if (!dg) ok = 1'b0;
        else begin
          tdig = d;
          ph   = (ph == dtv_pkg::PH_H0)  ? dtv_pkg::PH_H1 :
                 (ph == dtv_pkg::PH_MI0) ? dtv_pkg::PH_MI1 : dtv_pkg::PH_S1;
        end
      end
      dtv_pkg::PH_H1: begin
        if (!dg || int'(tdig) * 10 + int'(d) > 23) ok = 1'b0;
        else ph = dtv_pkg::PH_COLON;
      end
      dtv_pkg::PH_COLON: begin
        if (c != dtv_pkg::CHAR_COLON) ok = 1'b0;
        else ph = dtv_pkg::PH_MI0;
      end
      dtv_pkg::PH_MI1, dtv_pkg::PH_S1: begin
        if (!dg || int'(tdig) * 10 + int'(d) > 59) ok = 1'b0;
        else ph = (ph == dtv_pkg::PH_MI1) ? dtv_pkg::PH_TIME_DONE : dtv_pkg::PH_TAIL;
      end
      dtv_pkg::PH_TIME_DONE: begin
        if (c == dtv_pkg::CHAR_COLON) ph = dtv_pkg::PH_S0;
        else if (ws_char(c)) ph = dtv_pkg::PH_TAIL;
        else ok = 1'b0;
      end
      dtv_pkg::PH_TAIL: ok = ws_char(c);
      default: ok = 1'b1;
    endcase
  endtask

  task automatic predict_verdict(input logic [7:0] c, input bit last,
                                 output bit has_res, output bit res);
    bit ok;
    if (!bad && ph != dtv_pkg::PH_ENDED) begin
      if (c == dtv_pkg::CHAR_NUL) begin
        if (!phase_accepts(ph)) bad = 1'b1;
        ph = dtv_pkg::PH_ENDED;
      end else begin
        parse_char(c, ok);
        if (!ok) bad = 1'b1;
      end
    end
    has_res = last;
    res     = !bad && (ph == dtv_pkg::PH_ENDED || phase_accepts(ph));
    if (last) clear_parser();
  endtask

  function automatic logic [7:0] table_byte(byte ch);
    if (ch == "~") return dtv_pkg::CHAR_NUL;
    if (ch == "^") return CHAR_HIGH_ZERO;
    return 8'(ch);
  endfunction

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(5))
      0:       return dtv_pkg::CHAR_SPACE;
      1:       return dtv_pkg::CHAR_TAB;
      2:       return CHAR_LF;
      3:       return CHAR_VT;
      4:       return CHAR_FF;
      default: return dtv_pkg::CHAR_CR;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(1)) return 8'($urandom_range(255));
    case ($urandom_range(5))
      0:       return 8'(dtv_pkg::CHAR_ZERO + $urandom_range(9));
      1:       return dtv_pkg::CHAR_DASH;
      2:       return dtv_pkg::CHAR_COLON;
      3:       return dtv_pkg::CHAR_T_UP;
      4:       return dtv_pkg::CHAR_T_LO;
      default: return ws_byte();
    endcase
  endfunction

  function automatic logic [7:0] sep_byte(logic [7:0] c);
    return ($urandom_range(19) == 0) ? noise_byte() : c;
  endfunction

  task automatic push_digits(input int v, input int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    while (div > 0) begin
      text_bytes.push_back(8'(dtv_pkg::CHAR_ZERO + (v / div) % 10));
      div /= 10;
    end
  endtask

  task automatic build_random_text();
    int yr_v, mo_v, dy_v, top, cut;
    text_bytes.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(12, 1)) text_bytes.push_back(noise_byte());
      return;
    end
    repeat ($urandom_range(2)) text_bytes.push_back(ws_byte());
    case ($urandom_range(4))
      0:       yr_v = 400 * $urandom_range(24);
      1:       yr_v = 100 * $urandom_range(99);
      2:       yr_v = 4 * $urandom_range(2499);
      default: yr_v = $urandom_range(9999);
    endcase
    push_digits(yr_v, 4);
    text_bytes.push_back(sep_byte(dtv_pkg::CHAR_DASH));
    if ($urandom_range(9) == 0) mo_v = $urandom_range(1) ? 0 : $urandom_range(99, 13);
    else mo_v = $urandom_range(12, 1);
    push_digits(mo_v, 2);
    text_bytes.push_back(sep_byte(dtv_pkg::CHAR_DASH));
    top = (mo_v >= 1 && mo_v <= 12) ? month_length(mo_v, yr_v) : 31;
    case ($urandom_range(9))
      0:       dy_v = top + 1;
      1:       dy_v = 0;
      2:       dy_v = top;
      3:       dy_v = 1;
      default: dy_v = $urandom_range(top, 1);
    endcase
    push_digits(dy_v, 2);
    if ($urandom_range(3) != 0) begin
      repeat ($urandom_range(2)) text_bytes.push_back(ws_byte());
      case ($urandom_range(2))
        0:       text_bytes.push_back(dtv_pkg::CHAR_T_UP);
        1:       text_bytes.push_back(dtv_pkg::CHAR_T_LO);
        default: ;
      endcase
      push_digits(($urandom_range(9) == 0) ? $urandom_range(99, 24) : $urandom_range(23), 2);
      text_bytes.push_back(sep_byte(dtv_pkg::CHAR_COLON));
      push_digits(($urandom_range(9) == 0) ? $urandom_range(99, 60) : $urandom_range(59), 2);
      if ($urandom_range(1)) begin
        text_bytes.push_back(sep_byte(dtv_pkg::CHAR_COLON));
        push_digits(($urandom_range(9) == 0) ? $urandom_range(99, 60) : $urandom_range(59), 2);
      end
      repeat ($urandom_range(2)) text_bytes.push_back(ws_byte());
    end
    if ($urandom_range(6) == 0)
      text_bytes[$urandom_range(text_bytes.size() - 1)] = noise_byte();
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(text_bytes.size() - 1, 1);
      while (text_bytes.size() > cut) void'(text_bytes.pop_back());
    end
    case ($urandom_range(9))
      0, 1: text_bytes.push_back(dtv_pkg::CHAR_NUL);
      2: begin
        text_bytes.push_back(dtv_pkg::CHAR_NUL);
        repeat ($urandom_range(4, 1)) text_bytes.push_back(noise_byte());
      end
      default: ;
    endcase
  endtask

  function automatic int stall_pct(bit sender_side);
    if (mode == IDLE_BOTH) return 14;
    if (sender_side && mode == IDLE_SEND) return 47;
    if (!sender_side && mode == IDLE_RECV) return 47;
    return 0;
  endfunction

  task automatic send_text(input int answer);
    bit has_res, res;
    for (int i = 0; i < text_bytes.size(); i++) begin
      while ($urandom_range(99) < stall_pct(1'b1)) begin
        text_ch.valid <= 1'b0;
        @(posedge clk);
      end
      text_ch.valid     <= 1'b1;
      text_ch.char_code <= text_bytes[i];
      text_ch.is_last   <= (i == text_bytes.size() - 1);
      do @(posedge clk); while (!text_ch.ready);
      bytes_sent++;
      predict_verdict(text_bytes[i], i == text_bytes.size() - 1, has_res, res);
      if (has_res) verdict_q.push_back((answer == USE_MODEL) ? res : (answer != 0));
    end
    texts_sent++;
  endtask

  // Result receiver: random stalls, plus one long hold to back the block up.
  initial begin
    int hold_left;
    res_ch.ready = 1'b0;
    hold_left = HOLD_CYCLES;
    forever begin
      @(posedge clk);
      if (mode == IDLE_HOLD && hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= !($urandom_range(99) < stall_pct(1'b0));
      end
    end
  end

  always @(posedge clk) begin
    bit want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual valid_res=%b",
                 $time, res_ch.valid_res);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        verdicts_checked++;
        if (want) verdicts_true++;
        if (res_ch.valid_res !== want) begin
          $display("%0t: valid_res mismatch, expected %b, actual %b",
                   $time, want, res_ch.valid_res);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    string s;
    int phase_end;
    text_ch.valid     = 1'b0;
    text_ch.char_code = dtv_pkg::CHAR_NUL;
    text_ch.is_last   = 1'b0;
    rst  = 1'b1;
    mode = IDLE_NONE;
    clear_parser();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      s = dir_text[r];
      text_bytes.delete();
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(table_byte(s[i]));
      send_text(dir_answer[r]);
    end

    for (int p = 0; p <= int'(IDLE_HOLD); p++) begin
      mode = stall_mode_t'(p);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        build_random_text();
        send_text(USE_MODEL);
      end
    end
    text_ch.valid <= 1'b0;

    // drain
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d texts (%0d bytes); checked %0d verdicts, %0d of them valid,",
             texts_sent, bytes_sent, verdicts_checked, verdicts_true);
    $display("under free flow, sender gaps, receiver stalls, both, and a long result hold.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
